// ----- rtl/atsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_pkg
// Shared constants, fixed-point formats and pipeline context for the
// arctangent series unit.
// ----------------------------------------------------------------------------
package atsu_pkg;

  localparam int SERIES_TERMS_DEF    = 12;
  localparam int INPUT_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 28;

  // internal Q2.61 format
  localparam int Q_FRAC = 61;
  localparam int QW     = 64;
  localparam int PW     = 2 * QW;
  localparam int QB     = Q_FRAC + 1;
  localparam int RECIP_SHIFT = Q_FRAC + 4;

  localparam logic signed [QW-1:0] PI_Q         = 64'sh6487ED5110B4611A;
  localparam logic signed [QW-1:0] HALF_PI_Q    = 64'sh3243F6A8885A308D;
  localparam logic signed [QW-1:0] QUARTER_PI_Q = 64'sh1921FB54442D1847;

  typedef struct packed {
    logic xzero;
    logic yzero;
    logic yneg;
    logic xneg;
    logic swap;
    logic big;
    logic flip;
  } ctx_t;

  typedef struct packed {
    logic                  v;
    ctx_t                  ctx;
    logic                  s;
    logic [QW-1:0]         x2;
    logic signed [QW-1:0]  sum;
  } ser_side_t;

endpackage

// ----- rtl/atsu_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_in_if
// Coordinate channel: ordinate and abscissa with valid/ready.
// ----------------------------------------------------------------------------
interface atsu_in_if #(
  parameter int INPUT_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [INPUT_WIDTH-1:0] y_value;
  logic signed [INPUT_WIDTH-1:0] x_value;

  modport source (output valid, output y_value, output x_value, input ready);
  modport sink (input valid, input y_value, input x_value, output ready);
endinterface

// ----- rtl/atsu_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_out_if
// Angle channel: fixed-point angle with valid/ready.
// ----------------------------------------------------------------------------
interface atsu_out_if #(
  parameter int ANGLE_WIDTH = 31
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

// ----- rtl/atan2_series_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_series_unit_top
// Four-quadrant arctangent of a coordinate pair, returned in radians with
// ANGLE_FRAC_BITS fraction bits, by range reduction and an odd Taylor series.
// ----------------------------------------------------------------------------
// One beat in and one beat out per cycle while the output is not stalled.
// Each beat passes, in order, through two registers of magnitude folding,
// one restoring-division cell per ratio bit (62 cells), a pipelined
// squaring, one series term cell per odd term after the first (two
// pipelined multiplies and a reciprocal division by the odd index), the
// quadrant correction and rounding registers, and the output register. The
// whole pipe stalls only while the output register holds a beat not taken.
// ----------------------------------------------------------------------------
module atan2_series_unit_top
  import atsu_pkg::*;
#(
  parameter int SERIES_TERMS    = SERIES_TERMS_DEF,
  parameter int INPUT_WIDTH     = INPUT_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  atsu_in_if.sink         in_ch,
  atsu_out_if.source      out_ch
);
  localparam int IW = INPUT_WIDTH;
  localparam int DW = IW + 1;
  localparam int OW = ANGLE_FRAC_BITS + 3;
  localparam int SH = Q_FRAC - ANGLE_FRAC_BITS;
  localparam int NT = SERIES_TERMS;

  logic en;
  logic out_v;
  logic signed [OW-1:0] out_a;

  assign en           = !out_v || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_v;
  assign out_ch.angle = out_a;

  // fold signs
  logic          f1_v, f1_yneg, f1_xneg;
  logic [IW-1:0] f1_ym, f1_xm;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= in_ch.valid;
    end
    if (en) begin
      f1_yneg <= in_ch.y_value[IW-1];
      f1_xneg <= in_ch.x_value[IW-1];
      f1_ym   <= in_ch.y_value[IW-1] ? IW'(-in_ch.y_value) : IW'(in_ch.y_value);
      f1_xm   <= in_ch.x_value[IW-1] ? IW'(-in_ch.x_value) : IW'(in_ch.x_value);
    end
  end

  // order magnitudes, pick the ratio
  logic          swap_c, big_c;
  logic [DW-1:0] mn_c, mx_c;
  logic          f2_v;
  ctx_t          f2_ctx;
  logic [DW-1:0] f2_n, f2_d;

  always_comb begin
    swap_c = f1_ym > f1_xm;
    mn_c   = DW'(swap_c ? f1_xm : f1_ym);
    mx_c   = DW'(swap_c ? f1_ym : f1_xm);
    big_c  = {mn_c[DW-2:0], 1'b0} > mx_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
    if (en) begin
      f2_ctx <= '{xzero: f1_xm == '0, yzero: f1_ym == '0, yneg: f1_yneg,
                  xneg: f1_xneg, swap: swap_c, big: big_c,
                  flip: (f1_yneg != f1_xneg) && (f1_ym != '0)};
      f2_n   <= big_c ? mx_c - mn_c : mn_c;
      f2_d   <= big_c ? mx_c + mn_c : mx_c;
    end
  end

  // ratio divider chain
  logic          dv_v   [QB+1];
  ctx_t          dv_ctx [QB+1];
  logic [DW-1:0] dv_d   [QB+1];
  logic [DW-1:0] dv_r   [QB+1];
  logic [QB-1:0] dv_q   [QB+1];

  assign dv_v[0]   = f2_v;
  assign dv_ctx[0] = f2_ctx;
  assign dv_d[0]   = f2_d;
  assign dv_r[0]   = f2_n;
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < QB; i++) begin : g_div
    atsu_div_cell #(.DW(DW), .FIRST(i == 0)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(dv_v[i]), .ctx_in(dv_ctx[i]), .d_in(dv_d[i]), .r_in(dv_r[i]),
      .q_in(dv_q[i]),
      .v_out(dv_v[i+1]), .ctx_out(dv_ctx[i+1]), .d_out(dv_d[i+1]),
      .r_out(dv_r[i+1]), .q_out(dv_q[i+1])
    );
  end

  // square the ratio
  logic [PW-1:0] px;
  logic          sx_v   [2];
  ctx_t          sx_ctx [2];
  logic [QB-1:0] sx_q   [2];

  atsu_mul u_mul_sq (
    .clk(clk), .en(en), .a(QW'(dv_q[QB])), .b(QW'(dv_q[QB])), .p(px)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sx_v[0] <= 1'b0;
      sx_v[1] <= 1'b0;
    end else if (en) begin
      sx_v[0] <= dv_v[QB];
      sx_v[1] <= sx_v[0];
    end
    if (en) begin
      sx_ctx[0] <= dv_ctx[QB];
      sx_ctx[1] <= sx_ctx[0];
      sx_q[0]   <= dv_q[QB];
      sx_q[1]   <= sx_q[0];
    end
  end

  // series chain
  logic                 sr_v   [NT];
  ctx_t                 sr_ctx [NT];
  logic [QW-1:0]        sr_m   [NT];
  logic                 sr_s   [NT];
  logic [QW-1:0]        sr_x2  [NT];
  logic signed [QW-1:0] sr_sum [NT];

  assign sr_v[0]   = sx_v[1];
  assign sr_ctx[0] = sx_ctx[1];
  assign sr_m[0]   = QW'(sx_q[1]);
  assign sr_s[0]   = sx_ctx[1].big;
  assign sr_x2[0]  = px[Q_FRAC+QW-1:Q_FRAC];
  assign sr_sum[0] = sx_ctx[1].big ? -$signed(QW'(sx_q[1])) : $signed(QW'(sx_q[1]));

  for (genvar k = 1; k < NT; k++) begin : g_ser
    atsu_series_cell #(.ODD_N(2 * k + 1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(sr_v[k-1]), .ctx_in(sr_ctx[k-1]), .m_in(sr_m[k-1]),
      .s_in(sr_s[k-1]), .x2_in(sr_x2[k-1]), .sum_in(sr_sum[k-1]),
      .v_out(sr_v[k]), .ctx_out(sr_ctx[k]), .m_out(sr_m[k]),
      .s_out(sr_s[k]), .x2_out(sr_x2[k]), .sum_out(sr_sum[k])
    );
  end

  // quadrant correction and rounding
  localparam int ED = 6;
  localparam int EA = 4;
  logic                 e_v   [ED];
  ctx_t                 e_ctx [EA];
  logic signed [QW-1:0] e_a   [EA];
  logic [QW-1:0]        e5_m;
  logic                 e5_neg;
  logic [QW-SH-1:0]     e6_r;
  logic                 e6_neg;
  logic signed [QW-1:0] sel_a;

  always_comb begin
    if (!e_ctx[3].xzero) begin
      sel_a = e_a[3];
    end else if (e_ctx[3].yzero) begin
      sel_a = '0;
    end else begin
      sel_a = e_ctx[3].yneg ? -HALF_PI_Q : HALF_PI_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ED; k++) begin
        e_v[k] <= 1'b0;
      end
      out_v <= 1'b0;
    end else if (en) begin
      e_v[0] <= sr_v[NT-1];
      for (int k = 1; k < ED; k++) begin
        e_v[k] <= e_v[k-1];
      end
      out_v <= e_v[ED-1];
    end
    if (en) begin
      e_ctx[0] <= sr_ctx[NT-1];
      for (int k = 1; k < EA; k++) begin
        e_ctx[k] <= e_ctx[k-1];
      end
      e_a[0] <= sr_ctx[NT-1].big ? sr_sum[NT-1] + QUARTER_PI_Q : sr_sum[NT-1];
      e_a[1] <= e_ctx[0].swap ? HALF_PI_Q - e_a[0] : e_a[0];
      e_a[2] <= e_ctx[1].flip ? -e_a[1] : e_a[1];
      e_a[3] <= !e_ctx[2].xneg ? e_a[2]
              : (e_ctx[2].yneg ? e_a[2] - PI_Q : e_a[2] + PI_Q);
      e5_neg <= sel_a[QW-1];
      e5_m   <= sel_a[QW-1] ? QW'(-sel_a) : QW'(sel_a);
      e6_neg <= e5_neg;
      e6_r   <= (QW-SH)'((e5_m + (QW'(1) << (SH - 1))) >> SH);
      out_a  <= e6_neg ? OW'(-e6_r) : OW'(e6_r);
    end
  end
endmodule

// ----- rtl/atsu_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_mul
// Two-stage 64x64 unsigned multiplier built from four 32x32 partials.
// ----------------------------------------------------------------------------
module atsu_mul
  import atsu_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] a,
  input  logic [QW-1:0] b,
  output logic [PW-1:0] p
);
  localparam int HW = QW / 2;

  logic [QW-1:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= QW'(a[HW-1:0]) * QW'(b[HW-1:0]);
      p01 <= QW'(a[HW-1:0]) * QW'(b[QW-1:HW]);
      p10 <= QW'(a[QW-1:HW]) * QW'(b[HW-1:0]);
      p11 <= QW'(a[QW-1:HW]) * QW'(b[QW-1:HW]);
      p   <= PW'(p00) + (PW'(p01) << HW) + (PW'(p10) << HW) + (PW'(p11) << QW);
    end
  end
endmodule

// ----- rtl/atsu_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_div_cell
// One restoring-division cell: produces one quotient bit of the ratio.
// ----------------------------------------------------------------------------
module atsu_div_cell
  import atsu_pkg::*;
#(
  parameter int DW    = INPUT_WIDTH_DEF + 1,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  ctx_t          ctx_in,
  input  logic [DW-1:0] d_in,
  input  logic [DW-1:0] r_in,
  input  logic [QB-1:0] q_in,
  output logic          v_out,
  output ctx_t          ctx_out,
  output logic [DW-1:0] d_out,
  output logic [DW-1:0] r_out,
  output logic [QB-1:0] q_out
);
  logic [DW:0] cand;
  logic        qbit;

  always_comb begin
    cand = FIRST ? {1'b0, r_in} : {r_in, 1'b0};
    qbit = cand >= {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      ctx_out <= ctx_in;
      d_out   <= d_in;
      r_out   <= DW'(qbit ? cand - {1'b0, d_in} : cand);
      q_out   <= {q_in[QB-2:0], qbit};
    end
  end
endmodule

// ----- rtl/atsu_series_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_series_cell
// One odd Taylor term: next power by x^2, divide by its odd index,
// accumulate. Six stages.
// ----------------------------------------------------------------------------
module atsu_series_cell
  import atsu_pkg::*;
#(
  parameter int ODD_N = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  ctx_t                 ctx_in,
  input  logic [QW-1:0]        m_in,
  input  logic                 s_in,
  input  logic [QW-1:0]        x2_in,
  input  logic signed [QW-1:0] sum_in,
  output logic                 v_out,
  output ctx_t                 ctx_out,
  output logic [QW-1:0]        m_out,
  output logic                 s_out,
  output logic [QW-1:0]        x2_out,
  output logic signed [QW-1:0] sum_out
);
  localparam logic [QW-1:0] RECIP = QW'((66'd1 << RECIP_SHIFT) / ODD_N);
  localparam int DEPTH = 6;

  ser_side_t            sd [DEPTH];
  logic [PW-1:0]        pa, pb;
  logic [QW-1:0]        mnew;
  logic [QW-1:0]        m_d1, m_d2, m_d3, m_o;
  logic [QW-1:0]        q0r, rem, qf;
  logic signed [QW-1:0] sum_o;

  assign mnew = pa[Q_FRAC+QW-1:Q_FRAC];

  atsu_mul u_mul_pow (.clk(clk), .en(en), .a(m_in), .b(x2_in), .p(pa));
  atsu_mul u_mul_rcp (.clk(clk), .en(en), .a(mnew), .b(RECIP), .p(pb));

  assign qf = (rem >= QW'(ODD_N)) ? q0r + QW'(1) : q0r;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        sd[k].v <= 1'b0;
      end
    end else if (en) begin
      sd[0] <= '{v: v_in, ctx: ctx_in, s: s_in, x2: x2_in, sum: sum_in};
      for (int k = 1; k < DEPTH; k++) begin
        sd[k] <= sd[k-1];
      end
    end
    if (en) begin
      m_d1  <= mnew;
      m_d2  <= m_d1;
      m_d3  <= m_d2;
      m_o   <= m_d3;
      q0r   <= QW'(pb[PW-1:RECIP_SHIFT]);
      rem   <= m_d2 - QW'(pb[PW-1:RECIP_SHIFT]) * QW'(ODD_N);
      sum_o <= sd[DEPTH-2].s ? sd[DEPTH-2].sum + $signed(qf)
                             : sd[DEPTH-2].sum - $signed(qf);
    end
  end

  assign v_out   = sd[DEPTH-1].v;
  assign ctx_out = sd[DEPTH-1].ctx;
  assign s_out   = ~sd[DEPTH-1].s;
  assign x2_out  = sd[DEPTH-1].x2;
  assign m_out   = m_o;
  assign sum_out = sum_o;
endmodule

// ----- rtl/atsu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsu_checker
// Port-level checks of the arctangent unit, bound to the top level.
// ----------------------------------------------------------------------------
module atsu_checker #(
  parameter int OW = 31
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [OW-1:0] angle
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_angle_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(angle))
    else $error("angle changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
endmodule

bind atan2_series_unit_top atsu_checker #(.OW(ANGLE_FRAC_BITS + 3)) u_atsu_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .angle(out_ch.angle)
);
